// ----- rtl/core/xmcrc_pkg.sv -----
// Shared types and constants for the XMODEM-1K CRC receiver.
`default_nettype none

package xmcrc_pkg;

    // Input item kinds
    localparam logic [1:0] KIND_START   = 2'd0;
    localparam logic [1:0] KIND_BYTE    = 2'd1;
    localparam logic [1:0] KIND_TIMEOUT = 2'd2;

    // Protocol characters
    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_ACK = 8'h06;
    localparam logic [7:0] CH_NAK = 8'h15;
    localparam logic [7:0] CH_C   = 8'h43;
    localparam logic [7:0] CMP_SUM = 8'hFF;

    // CRC-16/CCITT
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam int unsigned DIDX_W = 10;

    // Register indexes
    localparam logic REG_BASE = 1'b0;

    typedef enum logic [6:0] {
        PH_IDLE   = 7'b0000001,
        PH_HEADER = 7'b0000010,
        PH_BLKNUM = 7'b0000100,
        PH_BLKCMP = 7'b0001000,
        PH_DATA   = 7'b0010000,
        PH_CRCHI  = 7'b0100000,
        PH_CRCLO  = 7'b1000000
    } t_phase;

    // Result item, without the parameter-wide block address
    typedef struct packed {
        logic              tx_valid;
        logic [7:0]        tx_byte;
        logic              data_valid;
        logic [DIDX_W-1:0] data_index;
        logic [7:0]        data_byte;
        logic              commit;
        logic              discard;
        logic              done_res;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/core/xmcrc_crc_step.sv -----
// Byte-wide CRC-16/CCITT update (MSB first, poly 0x1021).
`default_nettype none

module xmcrc_crc_step (
    input  wire logic [15:0] i_crc,
    input  wire logic [7:0]  i_byte,
    output logic      [15:0] o_crc
);

    always_comb begin
        logic [15:0] c;
        c = i_crc ^ {i_byte, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ xmcrc_pkg::CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        o_crc = c;
    end

endmodule

`default_nettype wire

// ----- rtl/core/xmcrc_ctrl.sv -----
// Protocol state machine: one item per step, result computed combinationally.
`default_nettype none

module xmcrc_ctrl #(
    parameter int unsigned BLOCK_BYTES = 1024,
    parameter int unsigned ADDR_BITS   = 28
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_step,
    input  wire logic [1:0]           i_kind,
    input  wire logic [7:0]           i_byte,
    input  wire logic [ADDR_BITS-1:0] i_base,
    output xmcrc_pkg::t_result        o_res,
    output logic      [ADDR_BITS-1:0] o_addr
);

    localparam int unsigned CW = $clog2(BLOCK_BYTES + 1);
    localparam logic [CW-1:0] LAST_IDX = CW'(BLOCK_BYTES - 1);
    localparam logic [ADDR_BITS-1:0] BLK_STEP = ADDR_BITS'(BLOCK_BYTES);

    xmcrc_pkg::t_phase     r_phase, n_phase;
    logic [7:0]            r_blk, n_blk;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [15:0]           r_crc, n_crc;
    logic [7:0]            r_crc_hi, n_crc_hi;
    logic [ADDR_BITS-1:0]  r_ofs, n_ofs;

    logic        staged;
    logic [15:0] crc_upd;
    logic [8:0]  cmp_sum;

    xmcrc_crc_step u_crc (
        .i_crc  (r_crc),
        .i_byte (i_byte),
        .o_crc  (crc_upd)
    );

    assign staged  = (r_phase == xmcrc_pkg::PH_DATA && r_cnt != '0) ||
                     r_phase == xmcrc_pkg::PH_CRCHI || r_phase == xmcrc_pkg::PH_CRCLO;
    assign cmp_sum = {1'b0, r_blk} + {1'b0, i_byte};

    always_comb begin
        n_phase  = r_phase;
        n_blk    = r_blk;
        n_cnt    = r_cnt;
        n_crc    = r_crc;
        n_crc_hi = r_crc_hi;
        n_ofs    = r_ofs;
        o_res    = '0;
        o_addr   = '0;
        case (i_kind)
            xmcrc_pkg::KIND_START: begin
                o_res.discard  = staged;
                o_res.tx_valid = 1'b1;
                o_res.tx_byte  = xmcrc_pkg::CH_C;
                n_ofs          = '0;
                n_cnt          = '0;
                n_crc          = '0;
                n_phase        = xmcrc_pkg::PH_HEADER;
            end
            xmcrc_pkg::KIND_TIMEOUT: begin
                if (r_phase == xmcrc_pkg::PH_HEADER) begin
                    o_res.tx_valid = 1'b1;
                    o_res.tx_byte  = xmcrc_pkg::CH_C;
                end else if (r_phase != xmcrc_pkg::PH_IDLE) begin
                    o_res.discard  = staged;
                    o_res.tx_valid = 1'b1;
                    o_res.tx_byte  = xmcrc_pkg::CH_NAK;
                    n_phase        = xmcrc_pkg::PH_HEADER;
                end
            end
            xmcrc_pkg::KIND_BYTE: begin
                case (r_phase)
                    xmcrc_pkg::PH_HEADER: begin
                        if (i_byte == xmcrc_pkg::CH_EOT) begin
                            o_res.tx_valid = 1'b1;
                            o_res.tx_byte  = xmcrc_pkg::CH_ACK;
                            o_res.done_res = 1'b1;
                            n_phase        = xmcrc_pkg::PH_IDLE;
                        end else if (i_byte == xmcrc_pkg::CH_STX) begin
                            n_phase = xmcrc_pkg::PH_BLKNUM;
                        end else begin
                            o_res.tx_valid = 1'b1;
                            o_res.tx_byte  = xmcrc_pkg::CH_NAK;
                        end
                    end
                    xmcrc_pkg::PH_BLKNUM: begin
                        n_blk   = i_byte;
                        n_phase = xmcrc_pkg::PH_BLKCMP;
                    end
                    xmcrc_pkg::PH_BLKCMP: begin
                        if (cmp_sum == {1'b0, xmcrc_pkg::CMP_SUM}) begin
                            n_cnt   = '0;
                            n_crc   = '0;
                            n_phase = xmcrc_pkg::PH_DATA;
                        end else begin
                            o_res.tx_valid = 1'b1;
                            o_res.tx_byte  = xmcrc_pkg::CH_NAK;
                            n_phase        = xmcrc_pkg::PH_HEADER;
                        end
                    end
                    xmcrc_pkg::PH_DATA: begin
                        o_res.data_valid = 1'b1;
                        o_res.data_index = xmcrc_pkg::DIDX_W'(r_cnt);
                        o_res.data_byte  = i_byte;
                        n_crc            = crc_upd;
                        n_cnt            = r_cnt + 1'b1;
                        if (r_cnt == LAST_IDX) begin
                            n_phase = xmcrc_pkg::PH_CRCHI;
                        end
                    end
                    xmcrc_pkg::PH_CRCHI: begin
                        n_crc_hi = i_byte;
                        n_phase  = xmcrc_pkg::PH_CRCLO;
                    end
                    xmcrc_pkg::PH_CRCLO: begin
                        o_res.tx_valid = 1'b1;
                        if ({r_crc_hi, i_byte} == r_crc) begin
                            o_res.tx_byte = xmcrc_pkg::CH_ACK;
                            o_res.commit  = 1'b1;
                            o_addr        = i_base + r_ofs;
                            n_ofs         = r_ofs + BLK_STEP;
                        end else begin
                            o_res.tx_byte = xmcrc_pkg::CH_NAK;
                            o_res.discard = 1'b1;
                        end
                        n_phase = xmcrc_pkg::PH_HEADER;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= xmcrc_pkg::PH_IDLE;
            r_blk    <= '0;
            r_cnt    <= '0;
            r_crc    <= '0;
            r_crc_hi <= '0;
            r_ofs    <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_blk    <= n_blk;
            r_cnt    <= n_cnt;
            r_crc    <= n_crc;
            r_crc_hi <= n_crc_hi;
            r_ofs    <= n_ofs;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/xmcrc_out_reg.sv -----
// Result register in front of the master stream port.
`default_nettype none

module xmcrc_out_reg #(
    parameter int unsigned ADDR_BITS = 28
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_load,
    input  wire xmcrc_pkg::t_result   i_res,
    input  wire logic [ADDR_BITS-1:0] i_addr,
    input  wire logic                 i_ready,
    output logic                      o_valid,
    output xmcrc_pkg::t_result        o_res,
    output logic      [ADDR_BITS-1:0] o_addr
);

    logic                 r_valid;
    xmcrc_pkg::t_result   r_res;
    logic [ADDR_BITS-1:0] r_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res  <= i_res;
            r_addr <= i_addr;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;
    assign o_addr  = r_addr;

endmodule

`default_nettype wire

// ----- rtl/core/xmodem_1k_crc_receiver.sv -----
// Top level of the XMODEM-1K CRC-16 receiver.
//
// Receiver side of XMODEM-1K with CRC-16/CCITT (poly 0x1021, init 0).
// Each input item is a start command, a received serial byte or a receive
// timeout (tuser = kind); each item yields exactly one result item that
// carries an optional reply byte ('C', ACK, NAK), an optional staged payload
// byte with its index inside the block, commit/discard strobes for the
// staged block, the flash address of a committed block (base + offset,
// wrapping modulo 2^ADDR_BITS) and an end-of-session flag on EOT.
// Rate: one item per clock sustained, back to back, while the result side
// does not stall. An item is held in the input register while the protocol
// step (state machine plus a byte-wide unrolled CRC update) runs, and is
// then loaded into the result register, from which the master port offers
// it; the result register loads whenever it is free or is being drained.
// Input tready drops only when both registers are full and the result side
// stalls. base_address is written through the APB port at address 0 and
// should be changed only while no item is in flight.
`default_nettype none

module xmodem_1k_crc_receiver #(
    parameter int unsigned BLOCK_BYTES = 1024,
    parameter int unsigned ADDR_BITS   = 28
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    // APB configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,

    // Input items
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
    input  wire logic [1:0]  s_axis_tuser,  // [1:0] kind

    // Result items
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata from bit 0: tx_byte[7:0], data_index[9:0], data_byte[7:0],
    // block_address[ADDR_BITS-1:0], zero fill
    output logic [((26 + ADDR_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // tuser from bit 0: tx_valid, data_valid, commit, discard, done_res
    output logic [4:0]       m_axis_tuser
);

    localparam int unsigned PAY_W = 26 + ADDR_BITS;
    localparam int unsigned TD_W  = ((PAY_W + 7) / 8) * 8;

    // Configuration register
    logic [ADDR_BITS-1:0] r_base;
    logic                 cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
        end else if (cfg_wr && paddr[2] == xmcrc_pkg::REG_BASE) begin
            r_base <= pwdata[ADDR_BITS-1:0];
        end
    end

    assign prdata = (paddr[2] == xmcrc_pkg::REG_BASE) ? 32'(r_base) : '0;

    // Input register
    logic       r_in_valid;
    logic [1:0] r_in_kind;
    logic [7:0] r_in_byte;
    logic       out_valid;
    logic       step;

    // The step fires when the result register is free or drains this cycle
    assign step          = r_in_valid && (!out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_kind <= s_axis_tuser;
            r_in_byte <= s_axis_tdata;
        end
    end

    // Protocol step
    xmcrc_pkg::t_result   step_res;
    logic [ADDR_BITS-1:0] step_addr;

    xmcrc_ctrl #(
        .BLOCK_BYTES (BLOCK_BYTES),
        .ADDR_BITS   (ADDR_BITS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_kind  (r_in_kind),
        .i_byte  (r_in_byte),
        .i_base  (r_base),
        .o_res   (step_res),
        .o_addr  (step_addr)
    );

    // Result register
    xmcrc_pkg::t_result   out_res;
    logic [ADDR_BITS-1:0] out_addr;

    xmcrc_out_reg #(
        .ADDR_BITS (ADDR_BITS)
    ) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step),
        .i_res   (step_res),
        .i_addr  (step_addr),
        .i_ready (m_axis_tready),
        .o_valid (out_valid),
        .o_res   (out_res),
        .o_addr  (out_addr)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = TD_W'({out_addr, out_res.data_byte, out_res.data_index,
                                  out_res.tx_byte});
    assign m_axis_tuser  = {out_res.done_res, out_res.discard, out_res.commit,
                            out_res.data_valid, out_res.tx_valid};

endmodule

`default_nettype wire

// ----- rtl/core/xmcrc_checker.sv -----
// Port-level checks for the XMODEM-1K receiver, bound to the top level.
`default_nettype none

module xmcrc_checker #(
    parameter int unsigned TD_W = 56
) (
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            m_axis_tvalid,
    input wire logic            m_axis_tready,
    input wire logic [TD_W-1:0] m_axis_tdata,
    input wire logic [4:0]      m_axis_tuser
);

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // A block is never both committed and discarded
    a_cm_dc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[2] && m_axis_tuser[3]))
        else $error("commit and discard together");

    // Commit always comes with an ACK reply
    a_cm_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[2] |->
            m_axis_tuser[0] && m_axis_tdata[7:0] == xmcrc_pkg::CH_ACK)
        else $error("commit without ACK");

    // A staged payload byte never carries a reply
    a_data_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0] && !m_axis_tuser[4])
        else $error("reply on a data byte");

endmodule

bind xmodem_1k_crc_receiver xmcrc_checker #(
    .TD_W (((26 + ADDR_BITS + 7) / 8) * 8)
) u_xmcrc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ----- bench/tb_top.sv -----
// Self-checking testbench for the XMODEM-1K CRC receiver.
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned BLOCK_BYTES = 1024;
    localparam int unsigned ADDR_W      = 28;
    localparam int unsigned TDATA_W     = ((26 + ADDR_W + 7) / 8) * 8;
    localparam int unsigned GAP_MAX     = 18;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam longint     CYCLE_LIMIT  = 2_000_000;
    localparam int unsigned REPORT_MAX  = 10;

    // kind code the block must ignore
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // one result item: the package fields plus the block address
    typedef struct packed {
        xmcrc_pkg::t_result res;
        logic [ADDR_W-1:0]  addr;
    } t_reply;

    // ------------------------------------------------------------------
    // DUT signals, inputs all at known values from time zero
    // ------------------------------------------------------------------
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;   // [7:0] rx_byte
    logic [1:0]  s_axis_tuser  = '0;   // [1:0] kind

    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    // from bit 0: tx_byte, data_index, data_byte, block_address, zero fill
    logic [TDATA_W-1:0] m_axis_tdata;
    // from bit 0: tx_valid, data_valid, commit, discard, done_res
    logic [4:0]         m_axis_tuser;

    xmodem_1k_crc_receiver #(
        .BLOCK_BYTES (BLOCK_BYTES),
        .ADDR_BITS   (ADDR_W)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Bench bookkeeping
    // ------------------------------------------------------------------
    t_reply  replies_due[$];      // expected result items, oldest first
    int      errors        = 0;
    int      items_sent    = 0;   // kind 3 items are not counted
    int      replies_seen  = 0;
    int      commits_seen  = 0;
    int      discards_seen = 0;
    longint  cycle_count   = 0;
    int      tx_gap_max    = GAP_MAX;
    int      rx_gap_max    = GAP_MAX;
    bit      hold_req      = 1'b0;
    logic [7:0] next_blk   = 8'd1;

    // ------------------------------------------------------------------
    // Receiver shadow state, updated once per accepted item
    // ------------------------------------------------------------------
    xmcrc_pkg::t_phase rx_phase   = xmcrc_pkg::PH_IDLE;
    logic [7:0]        rx_blk     = '0;
    logic [10:0]       rx_count   = '0;
    logic [15:0]       rx_crc     = '0;
    logic [7:0]        rx_crc_hi  = '0;
    logic [ADDR_W-1:0] rx_offset  = '0;
    logic [ADDR_W-1:0] base_addr  = '0;

    // CRC-16/CCITT, MSB first, one byte
    function automatic logic [15:0] crc16_next(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] v;
        v = c ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
            v = v[15] ? ((v << 1) ^ xmcrc_pkg::CRC_POLY) : (v << 1);
        return v;
    endfunction

    // Advance the shadow receiver by one item and return its result item.
    function automatic t_reply predict_reply(input logic [1:0] kind, input logic [7:0] b);
        t_reply r;
        logic   staged;
        r = '0;
        // a block counts as staged once its first data byte went out
        staged = (rx_phase == xmcrc_pkg::PH_DATA && rx_count != 0) ||
                 rx_phase == xmcrc_pkg::PH_CRCHI || rx_phase == xmcrc_pkg::PH_CRCLO;
        case (kind)
            xmcrc_pkg::KIND_START: begin
                r.res.discard  = staged;
                rx_offset      = '0;
                rx_count       = '0;
                rx_crc         = '0;
                rx_phase       = xmcrc_pkg::PH_HEADER;
                r.res.tx_valid = 1'b1;
                r.res.tx_byte  = xmcrc_pkg::CH_C;
            end
            xmcrc_pkg::KIND_TIMEOUT: begin
                if (rx_phase == xmcrc_pkg::PH_HEADER) begin
                    r.res.tx_valid = 1'b1;
                    r.res.tx_byte  = xmcrc_pkg::CH_C;
                end else if (rx_phase != xmcrc_pkg::PH_IDLE) begin
                    r.res.discard  = staged;
                    r.res.tx_valid = 1'b1;
                    r.res.tx_byte  = xmcrc_pkg::CH_NAK;
                    rx_phase       = xmcrc_pkg::PH_HEADER;
                end
            end
            xmcrc_pkg::KIND_BYTE: begin
                case (rx_phase)
                    xmcrc_pkg::PH_HEADER: begin
                        if (b == xmcrc_pkg::CH_EOT) begin
                            r.res.tx_valid = 1'b1;
                            r.res.tx_byte  = xmcrc_pkg::CH_ACK;
                            r.res.done_res = 1'b1;
                            rx_phase       = xmcrc_pkg::PH_IDLE;
                        end else if (b == xmcrc_pkg::CH_STX) begin
                            rx_phase = xmcrc_pkg::PH_BLKNUM;
                        end else begin
                            r.res.tx_valid = 1'b1;
                            r.res.tx_byte  = xmcrc_pkg::CH_NAK;
                        end
                    end
                    xmcrc_pkg::PH_BLKNUM: begin
                        rx_blk   = b;
                        rx_phase = xmcrc_pkg::PH_BLKCMP;
                    end
                    xmcrc_pkg::PH_BLKCMP: begin
                        if ({1'b0, rx_blk} + {1'b0, b} == {1'b0, xmcrc_pkg::CMP_SUM}) begin
                            rx_count = '0;
                            rx_crc   = '0;
                            rx_phase = xmcrc_pkg::PH_DATA;
                        end else begin
                            r.res.tx_valid = 1'b1;
                            r.res.tx_byte  = xmcrc_pkg::CH_NAK;
                            rx_phase       = xmcrc_pkg::PH_HEADER;
                        end
                    end
                    xmcrc_pkg::PH_DATA: begin
                        r.res.data_valid = 1'b1;
                        r.res.data_index = rx_count[xmcrc_pkg::DIDX_W-1:0];
                        r.res.data_byte  = b;
                        rx_crc   = crc16_next(rx_crc, b);
                        rx_count = rx_count + 11'd1;
                        if (rx_count >= BLOCK_BYTES)
                            rx_phase = xmcrc_pkg::PH_CRCHI;
                    end
                    xmcrc_pkg::PH_CRCHI: begin
                        rx_crc_hi = b;
                        rx_phase  = xmcrc_pkg::PH_CRCLO;
                    end
                    xmcrc_pkg::PH_CRCLO: begin
                        r.res.tx_valid = 1'b1;
                        if ({rx_crc_hi, b} == rx_crc) begin
                            r.res.tx_byte = xmcrc_pkg::CH_ACK;
                            r.res.commit  = 1'b1;
                            r.addr        = base_addr + rx_offset;
                            rx_offset     = rx_offset + ADDR_W'(BLOCK_BYTES);
                        end else begin
                            r.res.tx_byte = xmcrc_pkg::CH_NAK;
                            r.res.discard = 1'b1;
                        end
                        rx_phase = xmcrc_pkg::PH_HEADER;
                    end
                    default: ;
                endcase
            end
            default: ;  // unused kind: no effect at all
        endcase
        return r;
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        errors++;
        if (errors <= REPORT_MAX)
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h",
                     $realtime, what, want, got);
    endtask

    // Compare one accepted result item against the oldest expectation.
    task automatic check_reply(input logic [TDATA_W-1:0] d, input logic [4:0] u);
        t_reply want;
        t_reply got;
        logic [TDATA_W-27-ADDR_W:0] pad;
        got.res.tx_byte    = d[7:0];
        got.res.data_index = d[17:8];
        got.res.data_byte  = d[25:18];
        got.addr           = d[26 +: ADDR_W];
        pad                = d[TDATA_W-1:26+ADDR_W];
        got.res.tx_valid   = u[0];
        got.res.data_valid = u[1];
        got.res.commit     = u[2];
        got.res.discard    = u[3];
        got.res.done_res   = u[4];
        if (replies_due.size() == 0) begin
            note_mismatch("unexpected result item", 32'd0, 32'd1);
        end else begin
            want = replies_due.pop_front();
            replies_seen++;
            if (want.res.commit)  commits_seen++;
            if (want.res.discard) discards_seen++;
            if (got.res.tx_valid !== want.res.tx_valid)
                note_mismatch("tx_valid", 32'(want.res.tx_valid), 32'(got.res.tx_valid));
            if (got.res.tx_byte !== want.res.tx_byte)
                note_mismatch("tx_byte", 32'(want.res.tx_byte), 32'(got.res.tx_byte));
            if (got.res.data_valid !== want.res.data_valid)
                note_mismatch("data_valid", 32'(want.res.data_valid),
                              32'(got.res.data_valid));
            if (got.res.data_index !== want.res.data_index)
                note_mismatch("data_index", 32'(want.res.data_index),
                              32'(got.res.data_index));
            if (got.res.data_byte !== want.res.data_byte)
                note_mismatch("data_byte", 32'(want.res.data_byte),
                              32'(got.res.data_byte));
            if (got.res.commit !== want.res.commit)
                note_mismatch("commit", 32'(want.res.commit), 32'(got.res.commit));
            if (got.res.discard !== want.res.discard)
                note_mismatch("discard", 32'(want.res.discard), 32'(got.res.discard));
            if (got.addr !== want.addr)
                note_mismatch("block_address", 32'(want.addr), 32'(got.addr));
            if (got.res.done_res !== want.res.done_res)
                note_mismatch("done_res", 32'(want.res.done_res), 32'(got.res.done_res));
            if (pad !== '0)
                note_mismatch("tdata fill", 32'd0, 32'(pad));
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offer one item after a random gap. tvalid stays high across a
    // zero gap so it never gets two updates in the same step.
    task automatic send_item(input logic [1:0] kind, input logic [7:0] b);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        replies_due.push_back(predict_reply(kind, b));
        if (kind != KIND_UNUSED)
            items_sent++;
    endtask

    // Stop offering and let every outstanding item come back.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write base_address while the block is idle, then read it back.
    task automatic set_base(input logic [ADDR_W-1:0] value);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {xmcrc_pkg::REG_BASE, 2'b00};
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        base_addr = value;
        // straight into the read setup
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[ADDR_W-1:0] !== value)
            note_mismatch("base_address readback", 32'(value), prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_pacing(input bit burst);
        tx_gap_max = burst ? 0 : GAP_MAX;
        rx_gap_max = burst ? 0 : GAP_MAX;
    endtask

    // STX, block number and its complement (correct or corrupted)
    task automatic send_frame_start(input bit cmp_ok);
        send_item(xmcrc_pkg::KIND_BYTE, xmcrc_pkg::CH_STX);
        send_item(xmcrc_pkg::KIND_BYTE, next_blk);
        if (cmp_ok)
            send_item(xmcrc_pkg::KIND_BYTE, ~next_blk);
        else
            send_item(xmcrc_pkg::KIND_BYTE, ~next_blk ^ 8'($urandom_range(1, 255)));
        next_blk = next_blk + 8'd1;
    endtask

    task automatic send_payload(input int count, output logic [15:0] sum);
        logic [7:0] b;
        sum = '0;
        repeat (count) begin
            b   = 8'($urandom);
            sum = crc16_next(sum, b);
            send_item(xmcrc_pkg::KIND_BYTE, b);
        end
    endtask

    task automatic send_packet(input bit crc_ok);
        logic [15:0] sum;
        send_frame_start(1'b1);
        send_payload(BLOCK_BYTES, sum);
        if (!crc_ok)
            sum = sum ^ (16'h0001 << $urandom_range(0, 15));
        send_item(xmcrc_pkg::KIND_BYTE, sum[15:8]);
        send_item(xmcrc_pkg::KIND_BYTE, sum[7:0]);
    endtask

    // Random sessions: broken frames and noise, plus whole packets when
    // full_ok is set.
    task automatic run_sessions(input int min_items, input int min_good,
                                input bit full_ok);
        int          first;
        int          good;
        int          pick;
        logic [15:0] sum;
        first = items_sent;
        good  = 0;
        while (items_sent - first < min_items || good < min_good) begin
            // about one session in four runs with no idling on either side
            set_pacing($urandom_range(0, 3) == 0);
            send_item(xmcrc_pkg::KIND_START, 8'($urandom));
            repeat ($urandom_range(2, 5)) begin
                pick = full_ok ? $urandom_range(0, 99) : $urandom_range(43, 99);
                if (pick < 35) begin
                    send_packet(1'b1);
                    good++;
                end else if (pick < 43) begin
                    send_packet(1'b0);
                end else if (pick < 55) begin
                    send_frame_start(1'b0);
                end else if (pick < 80) begin
                    // packet cut short by a timeout or a fresh start
                    send_frame_start(1'b1);
                    if (full_ok && $urandom_range(0, 9) == 0) begin
                        send_payload(BLOCK_BYTES, sum);
                        if ($urandom_range(0, 1) == 1)
                            send_item(xmcrc_pkg::KIND_BYTE, 8'($urandom));
                    end else begin
                        send_payload($urandom_range(0, 40), sum);
                    end
                    if ($urandom_range(0, 3) == 0)
                        send_item(xmcrc_pkg::KIND_START, 8'($urandom));
                    else
                        send_item(xmcrc_pkg::KIND_TIMEOUT, 8'($urandom));
                end else begin
                    repeat ($urandom_range(1, 4))
                        send_item(2'($urandom_range(1, 3)), 8'($urandom));
                end
            end
            send_item(xmcrc_pkg::KIND_BYTE, xmcrc_pkg::CH_EOT);
            // a little traffic while the session is closed
            repeat ($urandom_range(0, 2))
                send_item(2'($urandom_range(1, 3)), 8'($urandom));
        end
        set_pacing(1'b0);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Short directed walk through the protocol corner cases.
    task automatic test_protocol_corners();
        send_item(xmcrc_pkg::KIND_BYTE, 8'h00);      // idle: byte gives an empty result
        send_item(xmcrc_pkg::KIND_TIMEOUT, 8'hFF);   // idle: timeout likewise
        send_item(KIND_UNUSED, 8'hFF);               // unused kind is ignored
        send_item(xmcrc_pkg::KIND_START, 8'h00);     // 'C'
        send_item(xmcrc_pkg::KIND_TIMEOUT, 8'h00);   // waiting for header: 'C' again
        send_item(xmcrc_pkg::KIND_BYTE, 8'hFF);      // not STX: NAK
        send_item(xmcrc_pkg::KIND_BYTE, 8'h00);
        send_item(xmcrc_pkg::KIND_BYTE, xmcrc_pkg::CH_STX);
        send_item(KIND_UNUSED, 8'h00);               // ignored inside a packet too
        send_item(xmcrc_pkg::KIND_BYTE, 8'h00);      // block number
        send_item(xmcrc_pkg::KIND_BYTE, 8'h00);      // bad complement: NAK
        send_item(xmcrc_pkg::KIND_BYTE, xmcrc_pkg::CH_STX);
        send_item(xmcrc_pkg::KIND_BYTE, 8'hFF);
        send_item(xmcrc_pkg::KIND_BYTE, 8'h00);      // good complement
        send_item(xmcrc_pkg::KIND_BYTE, 8'hFF);      // data index 0
        send_item(xmcrc_pkg::KIND_BYTE, 8'h00);      // data index 1
        send_item(xmcrc_pkg::KIND_TIMEOUT, 8'h00);   // NAK, staged data dropped
        send_item(xmcrc_pkg::KIND_BYTE, xmcrc_pkg::CH_STX);
        send_item(xmcrc_pkg::KIND_BYTE, 8'h01);
        send_item(xmcrc_pkg::KIND_TIMEOUT, 8'h00);   // NAK, nothing staged yet
        send_item(xmcrc_pkg::KIND_BYTE, xmcrc_pkg::CH_STX);
        send_item(xmcrc_pkg::KIND_BYTE, 8'h10);
        send_item(xmcrc_pkg::KIND_BYTE, 8'hEF);
        send_item(xmcrc_pkg::KIND_BYTE, 8'hA5);
        send_item(xmcrc_pkg::KIND_START, 8'hFF);     // restart mid-block: discard + 'C'
        send_item(xmcrc_pkg::KIND_BYTE, xmcrc_pkg::CH_EOT);  // ACK, session done
        send_item(xmcrc_pkg::KIND_BYTE, xmcrc_pkg::CH_EOT);  // idle again: empty result
    endtask

    // Base at the top of the address space: the second commit wraps, and a
    // bad CRC in between leaves the offset alone.
    task automatic test_address_wrap();
        set_base({ADDR_W{1'b1}});
        send_item(xmcrc_pkg::KIND_START, 8'h00);
        send_packet(1'b1);
        send_packet(1'b0);
        send_packet(1'b1);
        send_item(xmcrc_pkg::KIND_BYTE, xmcrc_pkg::CH_EOT);
    endtask

    // Receiver holds off for a long stretch while the sender streams.
    task automatic test_input_stall();
        logic [15:0] sum;
        set_pacing(1'b1);
        hold_req = 1'b1;
        send_item(xmcrc_pkg::KIND_START, 8'h00);
        send_frame_start(1'b1);
        send_payload(24, sum);
        send_item(xmcrc_pkg::KIND_TIMEOUT, 8'h00);
        set_pacing(1'b0);
    endtask

    task automatic test_random_sessions();
        set_base(ADDR_W'($urandom));
        run_sessions(150, 0, 1'b0);
        set_base('0);
        run_sessions(100, 0, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, one long hold-off on request
    // ------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_req) begin
                stall    = HOLD_CYCLES;
                hold_req = 1'b0;
            end else begin
                stall = $urandom_range(0, rx_gap_max);
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            check_reply(m_axis_tdata, m_axis_tuser);
        end
    end

    // Watchdog
    always @(posedge i_clk)
        cycle_count <= cycle_count + 1;

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb_top failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main_seq
        int spin;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_protocol_corners();
        test_address_wrap();
        test_input_stall();
        test_random_sessions();

        // let the tail drain, bounded
        s_axis_tvalid <= 1'b0;
        spin = 0;
        while (replies_due.size() != 0 && spin < 5000) begin
            @(posedge i_clk);
            spin++;
        end
        repeat (8) @(posedge i_clk);
        if (replies_due.size() != 0)
            note_mismatch("result items never delivered", 32'd0,
                          32'(replies_due.size()));

        $display("Ran %0d items through %0d results: %0d blocks committed, %0d discarded.",
                 items_sent, replies_seen, commits_seen, discards_seen);
        $display("Base moved over zero, all ones and a random value; one %0d-cycle hold-off.",
                 HOLD_CYCLES);
        if (errors == 0) begin
            $display("tb_top passed");
        end else begin
            $display("%0d mismatches in total", errors);
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/xmcrc_pkg.sv
rtl/core/xmcrc_crc_step.sv
rtl/core/xmcrc_ctrl.sv
rtl/core/xmcrc_out_reg.sv
rtl/core/xmodem_1k_crc_receiver.sv
rtl/core/xmcrc_checker.sv
bench/tb_top.sv
